// File: sv/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

    // Digits held in a numeric parameter before the sequence is swallowed (1..7)
    localparam logic [2:0] PARAM_DIGITS_MAX = 3'd4;

    // Special bytes
    localparam logic [7:0] BYTE_ESC       = 8'h1b;
    localparam logic [7:0] BYTE_CR        = 8'h0d;
    localparam logic [7:0] BYTE_LF        = 8'h0a;
    localparam logic [7:0] BYTE_DEL       = 8'h7f;
    localparam logic [7:0] BYTE_BS        = 8'h08;
    localparam logic [7:0] BYTE_CTRL_A    = 8'h01;
    localparam logic [7:0] BYTE_CTRL_C    = 8'h03;
    localparam logic [7:0] BYTE_CTRL_D    = 8'h04;
    localparam logic [7:0] BYTE_CTRL_E    = 8'h05;
    localparam logic [7:0] BYTE_CTRL_K    = 8'h0b;
    localparam logic [7:0] BYTE_CTRL_U    = 8'h15;
    localparam logic [7:0] BYTE_CTRL_W    = 8'h17;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_TILDE     = 8'h7e;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5b;
    localparam logic [7:0] BYTE_LETTER_O  = 8'h4f;
    localparam logic [7:0] BYTE_SEMI      = 8'h3b;
    localparam logic [7:0] BYTE_ZERO      = 8'h30;
    localparam logic [7:0] BYTE_NINE      = 8'h39;
    localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [7:0] BYTE_LETTER_A  = 8'h41;
    localparam logic [7:0] BYTE_LETTER_B  = 8'h42;
    localparam logic [7:0] BYTE_LETTER_C  = 8'h43;
    localparam logic [7:0] BYTE_LETTER_D  = 8'h44;
    localparam logic [7:0] BYTE_LETTER_F  = 8'h46;
    localparam logic [7:0] BYTE_LETTER_H  = 8'h48;
    localparam logic [7:0] BYTE_DIGIT_1   = 8'h31;
    localparam logic [7:0] BYTE_DIGIT_3   = 8'h33;
    localparam logic [7:0] BYTE_DIGIT_4   = 8'h34;
    localparam logic [7:0] BYTE_DIGIT_7   = 8'h37;
    localparam logic [7:0] BYTE_DIGIT_8   = 8'h38;

    typedef enum logic [2:0] {
        MODE_GROUND  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_PARAM   = 3'd3,
        MODE_SS3     = 3'd4,
        MODE_SWALLOW = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        KEY_CHAR      = 4'd0,
        KEY_ENTER     = 4'd1,
        KEY_BACKSPACE = 4'd2,
        KEY_DELETE    = 4'd3,
        KEY_LEFT      = 4'd4,
        KEY_RIGHT     = 4'd5,
        KEY_HOME      = 4'd6,
        KEY_END       = 4'd7,
        KEY_KILLEND   = 4'd8,
        KEY_KILLSTART = 4'd9,
        KEY_KILLWORD  = 4'd10,
        KEY_UP        = 4'd11,
        KEY_DOWN      = 4'd12,
        KEY_INTERRUPT = 4'd13,
        KEY_EOF       = 4'd14
    } key_code_t;

    // One possible key event
    typedef struct packed {
        logic      valid;
        key_code_t code;
    } key_t;

    // Decoder state
    typedef struct packed {
        mode_t      mode;
        logic [7:0] first_digit;
        logic [2:0] digit_count;
    } dec_state_t;

    // Decode result for one byte
    typedef struct packed {
        dec_state_t state_next;
        key_t       key;
        logic [7:0] char_byte;
    } dec_result_t;

endpackage

// File: sv/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: input register, decoder state, result register.
`timescale 1ns / 1ps
//
// Decodes a stream of bytes received from a terminal into editing key events.
// Slave channel s_axis_*: one received byte per beat in s_axis_tdata[7:0].
// Master channel m_axis_*: one key event per beat; tdata[3:0] is the key code,
// tdata[11:4] the printable byte for character events (zero otherwise),
// tdata[15:12] are zero. Many bytes (escape prefixes, unmapped control bytes,
// swallowed sequences) give no event at all.
// An accepted byte is held in the input register; its event is then loaded into the result
// register and presented on m_axis. Throughput: one byte per cycle while the receiver
// is not stalled with an event waiting, set by the single decode step between the input
// register and the result register.
// When the receiver stalls with an event waiting, a byte in the input register
// that would make a new event holds there and s_axis_tready drops; bytes that
// make no event still pass through and update the decoder state.
// Reset returns the decoder to ground mode with no parameter digits and empties
// both registers.
//
module terminal_key_sequence_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [3:0] key_code, [11:4] char_byte, [15:12] zero
);
    import tksd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    dec_state_t  state_reg;
    logic        out_valid_reg;
    key_code_t   out_code_reg;
    logic [7:0]  out_char_reg;
    dec_result_t dec;
    logic        out_free;
    logic        advance;

    tksd_decode u_decode (
        .state   (state_reg),
        .rx_byte (in_byte_reg),
        .result  (dec)
    );

    // Retire the held byte when its event (if any) has room
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (out_free || !dec.key.valid);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_GROUND;
            state_reg.first_digit <= 8'h00;
            state_reg.digit_count <= 3'd0;
        end
        else if (advance)
        begin
            state_reg <= dec.state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && dec.key.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.key.valid)
        begin
            out_code_reg <= dec.key.code;
            out_char_reg <= dec.char_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_char_reg, out_code_reg};

    // A byte blocked in the input register holds until it retires
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("blocked input byte lost or changed");

    // Character events carry a printable byte
    a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_code_reg == KEY_CHAR) |->
            (out_char_reg >= BYTE_SPACE) && (out_char_reg != BYTE_DEL))
        else $error("character event with non-printable byte");

    // Other events carry a zero byte
    a_key_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_code_reg != KEY_CHAR) |-> (out_char_reg == 8'h00))
        else $error("key event with nonzero byte");

    // Parameter digit count stays within the limit
    a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digit_count <= PARAM_DIGITS_MAX)
        else $error("digit count above limit");

endmodule

// File: sv/tksd_decode.sv
// Combinational next-state and key event decode for one received byte.
`timescale 1ns / 1ps

module tksd_decode (
    input  tksd_pkg::dec_state_t  state,
    input  logic [7:0]            rx_byte,
    output tksd_pkg::dec_result_t result
);
    import tksd_pkg::*;

    // Map a cursor final letter to its key
    function automatic key_t letter_key(input logic [7:0] b);
        key_t k;
        k.valid = 1'b1;
        k.code  = KEY_UP;
        case (b)
            BYTE_LETTER_A: k.code = KEY_UP;
            BYTE_LETTER_B: k.code = KEY_DOWN;
            BYTE_LETTER_C: k.code = KEY_RIGHT;
            BYTE_LETTER_D: k.code = KEY_LEFT;
            BYTE_LETTER_H: k.code = KEY_HOME;
            BYTE_LETTER_F: k.code = KEY_END;
            default:       k.valid = 1'b0;
        endcase
        return k;
    endfunction

    // Map a ground byte to its key; ESC is handled by the caller
    function automatic key_t plain_key(input logic [7:0] b);
        key_t k;
        k.valid = 1'b1;
        k.code  = KEY_CHAR;
        case (b)
            BYTE_CR, BYTE_LF:  k.code = KEY_ENTER;
            BYTE_DEL, BYTE_BS: k.code = KEY_BACKSPACE;
            BYTE_CTRL_A:       k.code = KEY_HOME;
            BYTE_CTRL_C:       k.code = KEY_INTERRUPT;
            BYTE_CTRL_D:       k.code = KEY_EOF;
            BYTE_CTRL_E:       k.code = KEY_END;
            BYTE_CTRL_K:       k.code = KEY_KILLEND;
            BYTE_CTRL_U:       k.code = KEY_KILLSTART;
            BYTE_CTRL_W:       k.code = KEY_KILLWORD;
            default:           k.valid = (b >= BYTE_SPACE);
        endcase
        return k;
    endfunction

    // Map the single digit of ESC [ n ~ to its key
    function automatic key_t param_key(input logic [7:0] d, input logic [2:0] cnt);
        key_t k;
        k.valid = (cnt == 3'd1);
        k.code  = KEY_HOME;
        case (d)
            BYTE_DIGIT_1, BYTE_DIGIT_7: k.code = KEY_HOME;
            BYTE_DIGIT_3:               k.code = KEY_DELETE;
            BYTE_DIGIT_4, BYTE_DIGIT_8: k.code = KEY_END;
            default:                    k.valid = 1'b0;
        endcase
        return k;
    endfunction

    logic       is_digit;
    dec_state_t nxt;
    key_t       key;

    assign is_digit = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_NINE);

    // Step the decoder mode and pick the key event
    always_comb
    begin
        nxt       = state;
        key.valid = 1'b0;
        key.code  = KEY_CHAR;
        case (state.mode)
            MODE_ESC:
            begin
                if (rx_byte == BYTE_LBRACKET)
                begin
                    nxt.mode = MODE_CSI;
                end
                else if (rx_byte == BYTE_LETTER_O)
                begin
                    nxt.mode = MODE_SS3;
                end
                else if (rx_byte == BYTE_ESC)
                begin
                    nxt.mode        = MODE_ESC;
                    nxt.digit_count = 3'd0;
                end
                else
                begin
                    nxt.mode = MODE_GROUND;
                    key      = plain_key(rx_byte);
                end
            end
            MODE_CSI:
            begin
                if (is_digit)
                begin
                    nxt.mode        = MODE_PARAM;
                    nxt.first_digit = rx_byte;
                    nxt.digit_count = 3'd1;
                end
                else
                begin
                    nxt.mode = MODE_GROUND;
                    key      = letter_key(rx_byte);
                end
            end
            MODE_PARAM:
            begin
                if (is_digit)
                begin
                    if (state.digit_count < PARAM_DIGITS_MAX)
                    begin
                        nxt.digit_count = state.digit_count + 3'd1;
                    end
                    else
                    begin
                        nxt.mode = MODE_SWALLOW;
                    end
                end
                else if (rx_byte == BYTE_SEMI)
                begin
                    nxt.mode = MODE_SWALLOW;
                end
                else
                begin
                    nxt.mode = MODE_GROUND;
                    if (rx_byte == BYTE_TILDE)
                    begin
                        key = param_key(state.first_digit, state.digit_count);
                    end
                end
            end
            MODE_SWALLOW:
            begin
                if ((rx_byte >= BYTE_FINAL_LO) && (rx_byte <= BYTE_TILDE))
                begin
                    nxt.mode = MODE_GROUND;
                end
            end
            MODE_SS3:
            begin
                nxt.mode = MODE_GROUND;
                key      = letter_key(rx_byte);
            end
            default:
            begin
                if (rx_byte == BYTE_ESC)
                begin
                    nxt.mode        = MODE_ESC;
                    nxt.digit_count = 3'd0;
                end
                else
                begin
                    nxt.mode = MODE_GROUND;
                    key      = plain_key(rx_byte);
                end
            end
        endcase
    end

    assign result.state_next = nxt;
    assign result.key        = key;
    assign result.char_byte  = (key.code == KEY_CHAR) ? rx_byte : 8'h00;

endmodule
